// ----- rtl/sv39ptw_pkg.sv -----
package sv39ptw_pkg;

  // Directory pool geometry
  localparam int POOL_DIRS = 64;
  localparam int DIR_W     = $clog2(POOL_DIRS);
  localparam int IDX_W     = 9;
  localparam int MEM_DEPTH = POOL_DIRS * (1 << IDX_W);
  localparam int MEM_AW    = DIR_W + IDX_W;

  // Field widths
  localparam int VA_W   = 39;
  localparam int PA_W   = 56;
  localparam int PPN_W  = 44;
  localparam int FLAG_W = 9;
  localparam int ATTR_W = 5;
  localparam int STAT_W = 2;
  localparam int OFF_W  = 12;

  // Table word: child link, ppn, flags from the top down
  localparam int MEM_W = DIR_W + PPN_W + FLAG_W;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;
  localparam logic REG_POOL_BASE = 1'b0;

  // Leaf flag bit positions
  localparam int F_V = 0;
  localparam int F_R = 1;
  localparam int F_W = 2;
  localparam int F_X = 3;
  localparam int F_U = 4;
  localparam int F_G = 5;
  localparam int F_A = 6;
  localparam int F_D = 7;
  localparam int F_C = 8;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NO_DIRS  = 2'd2
  } status_t;

  // Flag bits a map word sets on its leaf
  function automatic logic [FLAG_W-1:0] attr_flags(input logic [ATTR_W-1:0] attr);
    logic [FLAG_W-1:0] f;
    f = '0;
    f[F_V] = 1'b1;
    f[F_G] = 1'b1;
    f[F_R] = attr[0];
    f[F_A] = attr[0];
    f[F_W] = attr[1];
    f[F_D] = attr[1];
    f[F_X] = attr[2];
    f[F_U] = attr[3];
    f[F_C] = attr[4];
    return f;
  endfunction

endpackage

// ----- rtl/sv39_page_table_map_and_walk_core.sv -----
// Sv39 page table builder and walker over a pool of POOL_DIRS directories of
// 512 entries each, directory zero being the root. A map word (mode 0) walks
// the child links, takes new directories from the pool and writes a 4 KiB
// leaf (level three) or 2 MiB leaf (level two), ORing the new flag bits into
// the old ones; if the pool cannot supply the directories it needs, nothing
// changes and status reads "pool exhausted". A translate word (mode 1) walks
// at most three levels and returns the physical address, or "not mapped" for
// an invalid entry, a pointer outside the pool, a 1 GiB leaf or no leaf at all.
// All entries and child links live in one single-port table memory, so every
// level costs a read state and an evaluate state; a map makes a check walk,
// then a build walk and the leaf write unless the pool runs short, and one
// item is in flight at a time; a result still waiting in the output register
// adds its stall. After reset the block sweeps the table to zero, one entry a
// cycle, through all POOL_DIRS*512 = 32768 entries, and holds in_ready low
// meanwhile; the pool base register can be written during the sweep. The pool
// base register sits at byte address 0.
module sv39_page_table_map_and_walk_core
  import sv39ptw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  logic [VA_W-1:0]     virt_addr,
  input  logic [PA_W-1:0]     phys_addr,
  input  logic                huge_page,
  input  logic [ATTR_W-1:0]   attributes,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STAT_W-1:0]   status,
  output logic [PA_W-1:0]     out_phys_addr,
  output logic [PPN_W-1:0]    leaf_ppn,
  output logic [FLAG_W-1:0]   leaf_flags,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK_RD,
    S_CHK_EVAL,
    S_BLD_RD,
    S_BLD_EVAL,
    S_LEAF_RD,
    S_LEAF_EVAL,
    S_TR_RD,
    S_TR_EVAL,
    S_DONE
  } state_t;

  state_t               state;
  logic [MEM_AW-1:0]    clr_cnt;
  logic [PPN_W-1:0]     pool_base;
  logic [DIR_W-1:0]     dirs_used;

  // Latched input word
  logic [VA_W-1:0]      lat_va;
  logic [PPN_W-1:0]     lat_ppn;
  logic                 lat_psize;
  logic [ATTR_W-1:0]    lat_attr;

  // Walk position
  logic [DIR_W-1:0]     dir;
  logic [1:0]           level;

  // Pending result
  logic [STAT_W-1:0]    res_status;
  logic [PA_W-1:0]      res_pa;
  logic [PPN_W-1:0]     res_ppn;
  logic [FLAG_W-1:0]    res_flags;

  // Table memory
  logic [MEM_W-1:0]     mem [MEM_DEPTH];
  logic [MEM_W-1:0]     rdata;
  logic                 mem_we;
  logic [MEM_AW-1:0]    mem_addr;
  logic [MEM_W-1:0]     mem_wdata;

  // ------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == REG_POOL_BASE) ?
                  {{(PDATA_W-PPN_W){1'b0}}, pool_base} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_wr && paddr[3] == REG_POOL_BASE) begin
      pool_base <= pwdata[PPN_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Walk datapath
  // ------------------------------------------------------------------
  logic [1:0]           last_lvl;
  logic [IDX_W-1:0]     idx_sel;
  logic [DIR_W-1:0]     rd_child;
  logic [PPN_W-1:0]     rd_ppn;
  logic [FLAG_W-1:0]    rd_flags;
  logic [1:0]           need;
  logic [DIR_W:0]       need_sum;
  logic                 pool_short;
  logic [DIR_W-1:0]     new_dir;
  logic [PPN_W-1:0]     new_ptr_ppn;
  logic [PPN_W-1:0]     leaf_ppn_w;
  logic [FLAG_W-1:0]    leaf_flags_w;
  logic [PPN_W-1:0]     dir_diff;
  logic                 rwx;

  // 2 MiB leaves sit at level two (index 1), 4 KiB at level three
  assign last_lvl = lat_psize ? 2'd1 : 2'd2;

  always_comb begin
    case (level)
      2'd0:    idx_sel = lat_va[38:30];
      2'd1:    idx_sel = lat_va[29:21];
      default: idx_sel = lat_va[20:12];
    endcase
  end

  assign rd_child = rdata[MEM_W-1 -: DIR_W];
  assign rd_ppn   = rdata[FLAG_W +: PPN_W];
  assign rd_flags = rdata[FLAG_W-1:0];

  // Directories still needed once the walk meets a missing link
  assign need       = last_lvl - level;
  assign need_sum   = {1'b0, dirs_used} + (DIR_W+1)'(need);
  assign pool_short = need_sum > (DIR_W+1)'(POOL_DIRS - 1);

  assign new_dir     = dirs_used + DIR_W'(1);
  assign new_ptr_ppn = pool_base + PPN_W'(new_dir);

  assign leaf_ppn_w   = lat_psize ? {lat_ppn[PPN_W-1:IDX_W], {IDX_W{1'b0}}} : lat_ppn;
  assign leaf_flags_w = rd_flags | attr_flags(lat_attr);

  assign dir_diff = rd_ppn - pool_base;
  assign rwx      = rd_flags[F_R] || rd_flags[F_W] || rd_flags[F_X];

  // Memory port: the sweep owns it after reset, the walk afterwards
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = {dir, idx_sel};
    mem_wdata = rdata;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      S_BLD_EVAL: begin
        mem_we    = (rd_child == '0);
        mem_wdata = {new_dir, new_ptr_ppn, rd_flags | FLAG_W'(1 << F_V)};
      end
      S_LEAF_EVAL: begin
        mem_we    = 1'b1;
        mem_wdata = {rd_child, leaf_ppn_w, leaf_flags_w};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      dirs_used <= '0;
      out_valid <= 1'b0;
      dir       <= '0;
      level     <= '0;
    end else begin
      // drop the result word once taken, unless a new one replaces it
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + MEM_AW'(1);
          if (clr_cnt == MEM_AW'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            lat_va    <= virt_addr;
            lat_ppn   <= phys_addr[PA_W-1:OFF_W];
            lat_psize <= huge_page;
            lat_attr  <= attributes;
            dir       <= '0;
            level     <= '0;
            state     <= mode ? S_TR_RD : S_CHK_RD;
          end
        end

        // check walk: count the directories a map word needs
        S_CHK_RD: begin
          state <= S_CHK_EVAL;
        end

        S_CHK_EVAL: begin
          if (rd_child == '0 || level + 2'd1 == last_lvl) begin
            if (rd_child == '0 && pool_short) begin
              res_status <= ST_NO_DIRS;
              res_pa     <= '0;
              res_ppn    <= '0;
              res_flags  <= '0;
              state      <= S_DONE;
            end else begin
              dir   <= '0;
              level <= '0;
              state <= S_BLD_RD;
            end
          end else begin
            dir   <= rd_child;
            level <= level + 2'd1;
            state <= S_CHK_RD;
          end
        end

        // build walk: link in new directories where missing
        S_BLD_RD: begin
          state <= S_BLD_EVAL;
        end

        S_BLD_EVAL: begin
          if (rd_child == '0) begin
            dirs_used <= new_dir;
            dir       <= new_dir;
          end else begin
            dir <= rd_child;
          end
          level <= level + 2'd1;
          state <= (level + 2'd1 == last_lvl) ? S_LEAF_RD : S_BLD_RD;
        end

        S_LEAF_RD: begin
          state <= S_LEAF_EVAL;
        end

        S_LEAF_EVAL: begin
          res_status <= ST_DONE;
          res_pa     <= '0;
          res_ppn    <= leaf_ppn_w;
          res_flags  <= leaf_flags_w;
          state      <= S_DONE;
        end

        // translate walk
        S_TR_RD: begin
          state <= S_TR_EVAL;
        end

        S_TR_EVAL: begin
          if (rd_flags[F_V] && rwx && level != 2'd0) begin
            // leaf at level two or three; a root leaf would be a 1 GiB page
            res_status <= ST_DONE;
            res_pa     <= (level == 2'd2) ? {rd_ppn, lat_va[OFF_W-1:0]} :
                          {rd_ppn[PPN_W-1:IDX_W], lat_va[OFF_W+IDX_W-1:0]};
            res_ppn    <= rd_ppn;
            res_flags  <= rd_flags;
            state      <= S_DONE;
          end else if (rd_flags[F_V] && !rwx && dir_diff < PPN_W'(POOL_DIRS) &&
                       level != 2'd2) begin
            // follow the pointer one level down
            dir   <= dir_diff[DIR_W-1:0];
            level <= level + 2'd1;
            state <= S_TR_RD;
          end else begin
            res_status <= ST_UNMAPPED;
            res_pa     <= '0;
            res_ppn    <= '0;
            res_flags  <= '0;
            state      <= S_DONE;
          end
        end

        // hold the result until the output register is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            out_phys_addr <= res_pa;
            leaf_ppn      <= res_ppn;
            leaf_flags    <= res_flags;
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv39_page_table_map_and_walk_core_test.sv -----
module sv39_page_table_map_and_walk_core_test;
  import sv39ptw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTE_W = PPN_W + FLAG_W;
  localparam int DIR_ENTRIES = 1 << IDX_W;
  localparam logic MODE_MAP = 1'b0;
  localparam logic MODE_XLATE = 1'b1;
  localparam logic PS_4K = 1'b0;
  localparam logic PS_2M = 1'b1;
  localparam logic [PADDR_W-1:0] POOL_BASE_ADDR = PADDR_W'(REG_POOL_BASE) << 3;

  // One input word as the sender offers it
  typedef struct packed {
    logic              mode;
    logic [VA_W-1:0]   va;
    logic [PA_W-1:0]   pa;
    logic              huge_page;
    logic [ATTR_W-1:0] attr;
  } pt_word_t;

  // One result word as the block should return it
  typedef struct packed {
    status_t           status;
    logic [PA_W-1:0]   pa;
    logic [PPN_W-1:0]  ppn;
    logic [FLAG_W-1:0] flags;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              mode = 1'b0;
  logic [VA_W-1:0]   virt_addr = '0;
  logic [PA_W-1:0]   phys_addr = '0;
  logic              huge_page = 1'b0;
  logic [ATTR_W-1:0] attributes = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [PA_W-1:0]   out_phys_addr;
  logic [PPN_W-1:0]  leaf_ppn;
  logic [FLAG_W-1:0] leaf_flags;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow copy of the table memory, the child links and the pool state
  logic [PTE_W-1:0] pte_shadow [MEM_DEPTH];
  logic [DIR_W-1:0] child_shadow [MEM_DEPTH];
  int unsigned      dirs_taken = 0;
  logic [PPN_W-1:0] pool_base = '0;

  pt_word_t         words_to_send [$];
  walk_result_t     expected_walks [$];
  logic [VA_W-1:0]  mapped_vas [$];
  pt_word_t         offer;
  walk_result_t     want;

  // Traffic shaping, set by stimulus at falling edges; the receiver runs hold_count
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned long_hold_cycles = 0;
  int unsigned hold_count = 0;
  int unsigned mismatches = 0;

  // Keep most random traffic inside a few directory paths so that the pool
  // lasts long enough to reach deep walks
  logic [IDX_W-1:0] l1_picks [4] = '{9'd0, 9'd511, 9'd170, 9'd341};
  logic [IDX_W-1:0] l2_picks [8] = '{9'd0, 9'd511, 9'd1, 9'd2, 9'd100, 9'd255, 9'd256, 9'd300};

  sv39_page_table_map_and_walk_core dut (.*);

  always #10 clk = ~clk;

  // Predict one result word from the shadow tables; maps update the shadow
  function automatic walk_result_t walk_or_map(input pt_word_t w);
    walk_result_t     r;
    logic [IDX_W-1:0] idx [3];
    int unsigned      levels;
    int unsigned      need;
    int unsigned      dir_no;
    int unsigned      slot;
    bit               fresh;
    logic [PPN_W-1:0] ppn;
    logic [PPN_W-1:0] dir_off;
    logic [FLAG_W-1:0] fl;
    logic [PTE_W-1:0] pte;

    r = '{status: ST_UNMAPPED, pa: '0, ppn: '0, flags: '0};
    idx[0] = w.va[38:30];
    idx[1] = w.va[29:21];
    idx[2] = w.va[20:12];
    dir_no = 0;

    if (w.mode == MODE_XLATE) begin
      for (int lvl = 0; lvl < 3; lvl++) begin
        pte = pte_shadow[dir_no * DIR_ENTRIES + idx[lvl]];
        fl = pte[FLAG_W-1:0];
        ppn = pte[PTE_W-1:FLAG_W];
        if (!fl[F_V])
          return r;
        if (fl[F_R] || fl[F_W] || fl[F_X]) begin
          // a leaf in the root would be a 1 GiB page: not supported
          if (lvl == 2)
            r = '{status: ST_DONE, pa: {ppn, w.va[11:0]}, ppn: ppn, flags: fl};
          else if (lvl == 1)
            r = '{status: ST_DONE, pa: {ppn[PPN_W-1:9], w.va[20:0]}, ppn: ppn, flags: fl};
          return r;
        end
        dir_off = ppn - pool_base;
        if (dir_off >= POOL_DIRS)
          return r;
        dir_no = 32'(dir_off);
      end
      return r;
    end

    levels = w.huge_page ? 2 : 3;
    need = 0;
    fresh = 1'b0;
    // count the directories the build walk would take before touching anything
    for (int i = 0; i + 1 < levels; i++) begin
      if (fresh || child_shadow[dir_no * DIR_ENTRIES + idx[i]] == 0) begin
        need++;
        fresh = 1'b1;
      end else begin
        dir_no = 32'(child_shadow[dir_no * DIR_ENTRIES + idx[i]]);
      end
    end
    if (dirs_taken + need > POOL_DIRS - 1) begin
      r.status = ST_NO_DIRS;
      return r;
    end

    dir_no = 0;
    for (int i = 0; i + 1 < levels; i++) begin
      slot = dir_no * DIR_ENTRIES + idx[i];
      if (child_shadow[slot] == 0) begin
        dirs_taken++;
        child_shadow[slot] = DIR_W'(dirs_taken);
        // turning an entry into a pointer keeps its old flag bits
        fl = pte_shadow[slot][FLAG_W-1:0];
        fl[F_V] = 1'b1;
        pte_shadow[slot] = {PPN_W'(pool_base + dirs_taken), fl};
      end
      dir_no = 32'(child_shadow[slot]);
    end

    slot = dir_no * DIR_ENTRIES + idx[levels-1];
    ppn = w.pa[PA_W-1:OFF_W];
    if (levels == 2)
      ppn[8:0] = '0;
    fl = pte_shadow[slot][FLAG_W-1:0];
    fl[F_V] = 1'b1;
    fl[F_G] = 1'b1;
    if (w.attr[0]) begin
      fl[F_R] = 1'b1;
      fl[F_A] = 1'b1;
    end
    if (w.attr[1]) begin
      fl[F_W] = 1'b1;
      fl[F_D] = 1'b1;
    end
    if (w.attr[2]) fl[F_X] = 1'b1;
    if (w.attr[3]) fl[F_U] = 1'b1;
    if (w.attr[4]) fl[F_C] = 1'b1;
    pte_shadow[slot] = {ppn, fl};
    r = '{status: ST_DONE, pa: '0, ppn: ppn, flags: fl};
    return r;
  endfunction

  function automatic logic [VA_W-1:0] va_at(input int l1, input int l2, input int l3,
                                            input int off);
    return {9'(l1), 9'(l2), 9'(l3), 12'(off)};
  endfunction

  function automatic void queue_word(input logic m, input logic [VA_W-1:0] va,
                                     input logic [PA_W-1:0] pa, input logic ps,
                                     input logic [ATTR_W-1:0] attr);
    words_to_send.push_back('{mode: m, va: va, pa: pa, huge_page: ps, attr: attr});
    if (m == MODE_MAP) begin
      mapped_vas.push_back(va);
      if (mapped_vas.size() > 256)
        void'(mapped_vas.pop_front());
    end
  endfunction

  // Mostly maps and translates along known paths, a few fresh paths that
  // drain the pool, and leaves without r/w/x that point into or just beyond the pool
  function automatic void queue_random_word();
    logic             m;
    logic [VA_W-1:0]  va;
    logic [PA_W-1:0]  pa;
    logic             ps;
    logic [ATTR_W-1:0] attr;
    int unsigned      pick;

    pick = $urandom_range(99);
    pa = PA_W'({$urandom, $urandom});
    ps = ($urandom_range(3) == 0);
    attr = ATTR_W'($urandom);
    va = {l1_picks[$urandom_range(3)], l2_picks[$urandom_range(7)],
          ($urandom_range(9) == 0) ? 9'($urandom_range(3)) : 9'($urandom),
          12'($urandom)};
    m = 1'($urandom_range(1));
    if (m == MODE_XLATE) begin
      if (pick < 60 && mapped_vas.size() != 0) begin
        va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
        va[11:0] = 12'($urandom);
        if ($urandom_range(1))
          va[20:12] = 9'($urandom);
      end else if (pick >= 85) begin
        va = VA_W'({$urandom, $urandom});
      end
    end else begin
      if (pick < 4)
        va = VA_W'({$urandom, $urandom});
      if (pick >= 80 && pick < 90) begin
        attr[2:0] = '0;
        pa = {PPN_W'(pool_base + $urandom_range(70)), 12'($urandom)};
      end else if (pick >= 90 && pick < 95) begin
        pa = '1;
      end else if (pick >= 95) begin
        pa = '0;
      end
    end
    queue_word(m, va, pa, ps, attr);
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Write the pool base through a setup and an access phase, then read it back
  task automatic write_pool_base(input logic [PPN_W-1:0] base);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= POOL_BASE_ADDR;
    pwdata <= PDATA_W'(base);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pool_base = base;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    compare_field("pool base readback", 64'(base), 64'(prdata[PPN_W-1:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold until every queued word has been taken and every result checked
  task automatic wait_drained();
    @(negedge clk);
    while (words_to_send.size() != 0 || in_valid || expected_walks.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int count, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    @(negedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) queue_random_word();
    wait_drained();
  endtask

  // Sender: offer the next word once the slot is free, and predict each
  // word at the edge that accepts it
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_walks.push_back(walk_or_map(offer));
      if (!in_valid || in_ready) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = words_to_send.pop_front();
          in_valid <= 1'b1;
          mode <= offer.mode;
          virt_addr <= offer.va;
          phys_addr <= offer.pa;
          huge_page <= offer.huge_page;
          attributes <= offer.attr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result against the oldest prediction,
  // then pick ready for the next cycle; a long hold is counted up here
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_walks.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d pa %h",
                   $time, status, out_phys_addr);
          mismatches++;
        end else begin
          want = expected_walks.pop_front();
          compare_field("status", 64'(want.status), 64'(status));
          compare_field("out_phys_addr", 64'(want.pa), 64'(out_phys_addr));
          compare_field("leaf_ppn", 64'(want.ppn), 64'(leaf_ppn));
          compare_field("leaf_flags", 64'(want.flags), 64'(leaf_flags));
        end
      end
      if (hold_count < long_hold_cycles) begin
        hold_count <= hold_count + 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) begin
      pte_shadow[i] = '0;
      child_shadow[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The block clears its table for a while after reset; the register may
    // be written meanwhile and words simply wait on in_ready
    write_pool_base('0);

    @(negedge clk);
    // Empty table, ignored fields all ones
    queue_word(MODE_XLATE, '0, '1, PS_2M, '1);
    queue_word(MODE_MAP, '0, '0, PS_4K, 5'h1f);
    queue_word(MODE_XLATE, va_at(0, 0, 0, 'hfff), '0, PS_4K, '0);
    queue_word(MODE_MAP, '1, '1, PS_4K, 5'h1f);
    queue_word(MODE_XLATE, '1, '0, PS_4K, '0);
    // Rewrite a leaf: flags OR into the old ones, ppn replaced
    queue_word(MODE_MAP, '0, 56'h12_3456_789a_b000, PS_4K, 5'h00);
    queue_word(MODE_MAP, va_at(1, 0, 0, 0), 56'hab_cdef_0123_4567, PS_2M, 5'h01);
    queue_word(MODE_XLATE, va_at(1, 0, 'h1a5, 'habc), '0, PS_4K, '0);
    // Pointer over a 2 MiB leaf: keeps r, so the walk still stops there
    queue_word(MODE_MAP, va_at(1, 0, 3, 0), 56'h3c_5a5a_f0f0_1234, PS_4K, 5'h04);
    queue_word(MODE_XLATE, va_at(1, 0, 3, 'h123), '0, PS_4K, '0);
    // 2 MiB leaf over a pointer, then a map that follows the kept child link
    queue_word(MODE_MAP, va_at(0, 0, 0, 0), '1, PS_2M, 5'h02);
    queue_word(MODE_XLATE, va_at(0, 0, 7, 'h456), '0, PS_4K, '0);
    queue_word(MODE_MAP, va_at(0, 0, 5, 0), 56'h55_5555_5555_5555, PS_4K, 5'h08);
    queue_word(MODE_XLATE, va_at(0, 0, 5, 0), '0, PS_4K, '0);
    // Leaves without r/w/x: the walker treats them as pointers
    queue_word(MODE_MAP, va_at(2, 0, 0, 0), '0, PS_4K, 5'h10);
    queue_word(MODE_XLATE, va_at(2, 0, 0, 'h3ff), '0, PS_4K, '0);
    queue_word(MODE_MAP, va_at(2, 7, 0, 0), '0, PS_2M, 5'h18);
    queue_word(MODE_XLATE, va_at(2, 7, 2, 0), '0, PS_4K, '0);
    // Pointer outside the pool
    queue_word(MODE_MAP, va_at(2, 8, 0, 0), 56'h800_0000, PS_2M, 5'h00);
    queue_word(MODE_XLATE, va_at(2, 8, 0, 0), '0, PS_4K, '0);
    // Root entry never written
    queue_word(MODE_XLATE, va_at(300, 0, 0, 0), '1, PS_2M, '1);
    wait_drained();

    run_random(300, 0, 0);
    run_random(250, 87, 0);

    // Top base: new pointers wrap, old ones now land one directory off
    write_pool_base('1);
    run_random(250, 0, 87);

    write_pool_base(PPN_W'({$urandom, $urandom}));
    run_random(250, 12, 12);

    // Back to zero: block the receiver for a long stretch while words keep
    // coming so the core backs up, then wait until every result is checked
    write_pool_base('0);
    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_cycles = 400;
    repeat (60) queue_random_word();
    wait_drained();
    run_random(220, 0, 0);

    // Let any stray result show up before the verdict
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("sv39_page_table_map_and_walk_core test passed");
    end else begin
      $display("sv39_page_table_map_and_walk_core test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, clearing pass included
  initial begin
    #40_000_000;
    $display("sv39_page_table_map_and_walk_core test failed");
    $finish;
  end

endmodule
